@@ rtl/luenberger_state_observer_macros.svh @@
// Assertion macros for the state observer checker
`ifndef LUENBERGER_STATE_OBSERVER_MACROS_SVH
`define LUENBERGER_STATE_OBSERVER_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define LSO_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lso check failed");

// antecedent holds -> consequent holds in the next cycle
`define LSO_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lso check failed");

`endif

@@ rtl/lso_pkg.sv @@
// Shared types and constants of the state observer
`default_nettype none
package lso_pkg;

	localparam int COEF_W     = 16;
	localparam int REG_W      = 48;
	localparam int REG_COUNT  = 6;
	localparam int ADDR_W     = 6;
	localparam int DATA_W     = 64;
	localparam int GUARD_BITS = 3;

	localparam logic [2:0] REG_A_ROW0 = 3'd0;
	localparam logic [2:0] REG_A_ROW1 = 3'd1;
	localparam logic [2:0] REG_A_ROW2 = 3'd2;
	localparam logic [2:0] REG_B_COL  = 3'd3;
	localparam logic [2:0] REG_C_ROW  = 3'd4;
	localparam logic [2:0] REG_L_COL  = 3'd5;

	localparam logic [REG_W-1:0] RST_A_ROW0 = 48'd278528657721590;
	localparam logic [REG_W-1:0] RST_A_ROW1 = 48'd2048;
	localparam logic [REG_W-1:0] RST_A_ROW2 = 48'd134217728;
	localparam logic [REG_W-1:0] RST_B_COL  = 48'd2048;
	localparam logic [REG_W-1:0] RST_C_ROW  = 48'd42965139567;
	localparam logic [REG_W-1:0] RST_L_COL  = 48'd81673043715914;

	typedef logic [REG_COUNT-1:0][REG_W-1:0] regs_t;

	// accumulation target of a term
	typedef enum logic [1:0] {
		DEST_X0 = 2'd0,
		DEST_X1 = 2'd1,
		DEST_X2 = 2'd2,
		DEST_Y  = 2'd3
	} dest_t;

	// operand source of a term
	typedef enum logic [2:0] {
		SRC_X0 = 3'd0,
		SRC_X1 = 3'd1,
		SRC_X2 = 3'd2,
		SRC_U  = 3'd3,
		SRC_E  = 3'd4
	} src_t;

	typedef struct packed {
		logic  load;
		logic  issue;
		dest_t dest;
		src_t  src;
		logic  commit;
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/lso_regs.sv @@
// Configuration register file with APB-style write and read
`default_nettype none
module lso_regs (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [lso_pkg::ADDR_W-1:0]  paddr,
	input  wire  [lso_pkg::DATA_W-1:0]  pwdata,
	output logic [lso_pkg::DATA_W-1:0]  prdata,
	output lso_pkg::regs_t              regs
);
	import lso_pkg::*;

	regs_t      regs_q;
	logic       wr_en;
	logic [2:0] idx;

	assign idx   = paddr[5:3];
	assign wr_en = psel && penable && pwrite;
	assign regs  = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_A_ROW0] <= RST_A_ROW0;
			regs_q[REG_A_ROW1] <= RST_A_ROW1;
			regs_q[REG_A_ROW2] <= RST_A_ROW2;
			regs_q[REG_B_COL]  <= RST_B_COL;
			regs_q[REG_C_ROW]  <= RST_C_ROW;
			regs_q[REG_L_COL]  <= RST_L_COL;
		end else if (wr_en) begin
			unique case (idx)
				REG_A_ROW0: regs_q[REG_A_ROW0] <= pwdata[REG_W-1:0];
				REG_A_ROW1: regs_q[REG_A_ROW1] <= pwdata[REG_W-1:0];
				REG_A_ROW2: regs_q[REG_A_ROW2] <= pwdata[REG_W-1:0];
				REG_B_COL:  regs_q[REG_B_COL]  <= pwdata[REG_W-1:0];
				REG_C_ROW:  regs_q[REG_C_ROW]  <= pwdata[REG_W-1:0];
				REG_L_COL:  regs_q[REG_L_COL]  <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_A_ROW0: prdata = {{(DATA_W-REG_W){1'b0}}, regs_q[REG_A_ROW0]};
			REG_A_ROW1: prdata = {{(DATA_W-REG_W){1'b0}}, regs_q[REG_A_ROW1]};
			REG_A_ROW2: prdata = {{(DATA_W-REG_W){1'b0}}, regs_q[REG_A_ROW2]};
			REG_B_COL:  prdata = {{(DATA_W-REG_W){1'b0}}, regs_q[REG_B_COL]};
			REG_C_ROW:  prdata = {{(DATA_W-REG_W){1'b0}}, regs_q[REG_C_ROW]};
			REG_L_COL:  prdata = {{(DATA_W-REG_W){1'b0}}, regs_q[REG_L_COL]};
			default:    prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/lso_ctrl.sv @@
// Sequencer that steps the shared multiply-accumulate through all terms
`default_nettype none
module lso_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  wire            out_stall,
	output lso_pkg::cmd_t  cmd
);
	import lso_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	dest_t  dest_q, dest_d;
	src_t   src_q, src_d;
	logic   out_valid_q;
	logic   accept, last_term, commit;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && (state_q == S_IDLE);
	assign last_term = (dest_q == DEST_X2) && (src_q == SRC_E);
	assign commit    = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign cmd.load   = accept;
	assign cmd.issue  = (state_q == S_RUN);
	assign cmd.dest   = dest_q;
	assign cmd.src    = src_q;
	assign cmd.commit = commit;

	// yhat group has three terms, each state row has five
	always_comb begin
		dest_d = dest_q;
		src_d  = src_q;
		if (accept) begin
			dest_d = DEST_Y;
			src_d  = SRC_X0;
		end else if (state_q == S_RUN) begin
			unique case (src_q)
				SRC_X0: src_d = SRC_X1;
				SRC_X1: src_d = SRC_X2;
				SRC_X2: begin
					if (dest_q == DEST_Y) begin
						src_d  = SRC_X0;
						dest_d = DEST_X0;
					end else begin
						src_d = SRC_U;
					end
				end
				SRC_U:  src_d = SRC_E;
				SRC_E: begin
					src_d = SRC_X0;
					unique case (dest_q)
						DEST_X0: dest_d = DEST_X1;
						DEST_X1: dest_d = DEST_X2;
						DEST_X2: dest_d = DEST_X2;
						DEST_Y:  dest_d = DEST_X0;
					endcase
				end
				default: src_d = SRC_X0;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_RUN;
			S_RUN:   if (last_term) state_d = S_DRAIN;
			S_DRAIN: state_d = S_DONE;
			S_DONE:  if (commit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dest_q      <= DEST_Y;
			src_q       <= SRC_X0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dest_q  <= dest_d;
			src_q   <= src_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/lso_datapath.sv @@
// Shared multiplier, accumulator, saturation and state registers
`default_nettype none
module lso_datapath #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int STATE_WIDTH    = 24,
	parameter int COEF_FRAC_BITS = 11
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  lso_pkg::cmd_t                   cmd,
	input  lso_pkg::regs_t                  regs,
	input  wire signed [SAMPLE_WIDTH-1:0]   u_sample,
	input  wire signed [SAMPLE_WIDTH-1:0]   y_sample,
	output logic signed [STATE_WIDTH-1:0]   y_predicted,
	output logic signed [STATE_WIDTH-1:0]   x0_estimate,
	output logic signed [STATE_WIDTH-1:0]   x1_estimate,
	output logic signed [STATE_WIDTH-1:0]   x2_estimate
);
	import lso_pkg::*;

	localparam int EW = ((SAMPLE_WIDTH > STATE_WIDTH) ? SAMPLE_WIDTH : STATE_WIDTH) + 1;
	localparam int PW = COEF_W + EW;
	localparam int AW = PW + GUARD_BITS;
	localparam logic signed [AW-1:0] SAT_MAX =
		{{(AW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
	localparam logic signed [AW-1:0] SAT_MIN = ~SAT_MAX;

	logic signed [SAMPLE_WIDTH-1:0] u_q, y_q;
	logic signed [STATE_WIDTH-1:0]  x_q [3];
	logic signed [STATE_WIDTH-1:0]  next_q [3];
	logic signed [STATE_WIDTH-1:0]  yhat_q, yout_q;
	logic signed [AW-1:0]           acc_q;
	logic signed [PW-1:0]           prod_s1;
	logic                           issue_s1;
	dest_t                          dest_s1;
	src_t                           src_s1;

	logic [REG_W-1:0]         reg_sel;
	logic [1:0]               lane;
	logic signed [COEF_W-1:0] coef;
	logic signed [EW-1:0]     operand, err;
	logic signed [PW-1:0]     shifted;
	logic signed [AW-1:0]     term, sum, sat;
	logic                     first, last;

	assign err = {{(EW-SAMPLE_WIDTH){y_q[SAMPLE_WIDTH-1]}}, y_q}
		- {{(EW-STATE_WIDTH){yhat_q[STATE_WIDTH-1]}}, yhat_q};

	always_comb begin
		reg_sel = regs[REG_C_ROW];
		lane    = 2'd0;
		unique case (cmd.src)
			SRC_X0: lane = 2'd0;
			SRC_X1: lane = 2'd1;
			SRC_X2: lane = 2'd2;
			default: lane = cmd.dest;
		endcase
		if (cmd.dest == DEST_Y) begin
			reg_sel = regs[REG_C_ROW];
		end else begin
			unique case (cmd.src)
				SRC_U: reg_sel = regs[REG_B_COL];
				SRC_E: reg_sel = regs[REG_L_COL];
				default: begin
					unique case (cmd.dest)
						DEST_X0: reg_sel = regs[REG_A_ROW0];
						DEST_X1: reg_sel = regs[REG_A_ROW1];
						default: reg_sel = regs[REG_A_ROW2];
					endcase
				end
			endcase
		end
	end

	always_comb begin
		unique case (lane)
			2'd0:    coef = reg_sel[COEF_W-1:0];
			2'd1:    coef = reg_sel[2*COEF_W-1:COEF_W];
			default: coef = reg_sel[3*COEF_W-1:2*COEF_W];
		endcase
	end

	always_comb begin
		unique case (cmd.src)
			SRC_X1: operand = {{(EW-STATE_WIDTH){x_q[1][STATE_WIDTH-1]}}, x_q[1]};
			SRC_X2: operand = {{(EW-STATE_WIDTH){x_q[2][STATE_WIDTH-1]}}, x_q[2]};
			SRC_U:  operand = {{(EW-SAMPLE_WIDTH){u_q[SAMPLE_WIDTH-1]}}, u_q};
			SRC_E:  operand = err;
			default: operand = {{(EW-STATE_WIDTH){x_q[0][STATE_WIDTH-1]}}, x_q[0]};
		endcase
	end

	// floor(c*v / 2^F) summed exactly, saturated at the end of each group
	assign shifted = prod_s1 >>> COEF_FRAC_BITS;
	assign term    = {{GUARD_BITS{shifted[PW-1]}}, shifted};
	assign first   = (src_s1 == SRC_X0);
	assign last    = ((dest_s1 == DEST_Y) && (src_s1 == SRC_X2)) || (src_s1 == SRC_E);
	assign sum     = first ? term : acc_q + term;

	always_comb begin
		if (sum > SAT_MAX) begin
			sat = SAT_MAX;
		end else if (sum < SAT_MIN) begin
			sat = SAT_MIN;
		end else begin
			sat = sum;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			u_q <= u_sample;
			y_q <= y_sample;
		end
		if (cmd.issue) begin
			prod_s1 <= coef * operand;
			dest_s1 <= cmd.dest;
			src_s1  <= cmd.src;
		end
		if (issue_s1) begin
			acc_q <= sum;
			if (last) begin
				unique case (dest_s1)
					DEST_X0: next_q[0] <= sat[STATE_WIDTH-1:0];
					DEST_X1: next_q[1] <= sat[STATE_WIDTH-1:0];
					DEST_X2: next_q[2] <= sat[STATE_WIDTH-1:0];
					DEST_Y:  yhat_q    <= sat[STATE_WIDTH-1:0];
				endcase
			end
		end
		if (cmd.commit) begin
			yout_q <= yhat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			x_q[0]   <= '0;
			x_q[1]   <= '0;
			x_q[2]   <= '0;
		end else begin
			issue_s1 <= cmd.issue;
			if (cmd.commit) begin
				x_q[0] <= next_q[0];
				x_q[1] <= next_q[1];
				x_q[2] <= next_q[2];
			end
		end
	end

	assign y_predicted = yout_q;
	assign x0_estimate = x_q[0];
	assign x1_estimate = x_q[1];
	assign x2_estimate = x_q[2];

endmodule
`default_nettype wire

@@ rtl/luenberger_state_observer.sv @@
// Third-order Luenberger state observer, top level.
// Each input transfer (u_sample, y_sample) yields one result transfer carrying
// yhat = C.x of the old estimate and the new estimate x' = A.x + B.u + L.e,
// saturated to STATE_WIDTH. The 18 multiply-accumulate terms run one per
// cycle through a single shared multiplier, and a new input is taken only
// after the previous result has been committed to the output; a result
// left stalled at the output holds off completion of the next item. The
// six 48-bit coefficient registers sit at byte addresses 8*i of the APB port.
`default_nettype none
module luenberger_state_observer #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int STATE_WIDTH    = 24,
	parameter int COEF_FRAC_BITS = 11
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire signed [SAMPLE_WIDTH-1:0]   u_sample,
	input  wire signed [SAMPLE_WIDTH-1:0]   y_sample,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic signed [STATE_WIDTH-1:0]   y_predicted,
	output logic signed [STATE_WIDTH-1:0]   x0_estimate,
	output logic signed [STATE_WIDTH-1:0]   x1_estimate,
	output logic signed [STATE_WIDTH-1:0]   x2_estimate,
	input  wire                             psel,
	input  wire                             penable,
	input  wire                             pwrite,
	input  wire  [lso_pkg::ADDR_W-1:0]      paddr,
	input  wire  [lso_pkg::DATA_W-1:0]      pwdata,
	output logic [lso_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);
	import lso_pkg::*;

	regs_t regs;
	cmd_t  cmd;

	assign pready = 1'b1;

	lso_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.regs    (regs)
	);

	lso_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	lso_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.STATE_WIDTH    (STATE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.regs        (regs),
		.u_sample    (u_sample),
		.y_sample    (y_sample),
		.y_predicted (y_predicted),
		.x0_estimate (x0_estimate),
		.x1_estimate (x1_estimate),
		.x2_estimate (x2_estimate)
	);

endmodule
`default_nettype wire

@@ rtl/lso_checker.sv @@
// Port-level checks of the state observer and their binding
`default_nettype none
`include "luenberger_state_observer_macros.svh"
module lso_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_stall,
	input wire out_valid,
	input wire out_stall,
	input wire pready
);

	`LSO_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`LSO_ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall)
	`LSO_ASSERT_NOW(a_out_while_busy, clk, arst_n, $rose(out_valid), $past(in_stall))
	`LSO_ASSERT_NOW(a_pready_high, clk, arst_n, 1'b1, pready)

endmodule

bind luenberger_state_observer lso_checker u_lso_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pready    (pready)
);
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the third-order Luenberger state observer
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lso_pkg::*;

	localparam int SW          = 16;
	localparam int XW          = 24;
	localparam int FRAC        = 11;
	localparam int CLK_HALF    = 4;
	localparam int RESET_LEN   = 12;
	localparam int LATENCY     = 32;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 130;
	localparam int MAX_REPORTS = 10;

	localparam logic [2:0] REG_SPARE6 = 3'd6;
	localparam logic [2:0] REG_SPARE7 = 3'd7;

	localparam logic [REG_W-1:0] RESET_VALUES [REG_COUNT] = '{
		RST_A_ROW0, RST_A_ROW1, RST_A_ROW2, RST_B_COL, RST_C_ROW, RST_L_COL
	};

	typedef struct packed {
		logic signed [XW-1:0] y_predicted;
		logic signed [XW-1:0] x0;
		logic signed [XW-1:0] x1;
		logic signed [XW-1:0] x2;
	} estimate_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [2:0]           reg_idx;
		logic [63:0]          value;
		logic signed [SW-1:0] u;
		logic signed [SW-1:0] y;
		logic                 typed;
		estimate_t            result;
	} stim_row_t;

	typedef enum int {COEF_RESET, COEF_GENTLE, COEF_SMALL, COEF_FULL, COEF_EXTREME} coef_mode_t;

	localparam estimate_t NONE = '0;
	localparam int DIRECTED_ROWS = 45;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd0, 16'sd0, 1'b1, '{24'sd0, 24'sd0, 24'sd0, 24'sd0}},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd32767, 16'sd0, 1'b1,
			'{24'sd0, 24'sd32767, 24'sd0, 24'sd0}},
		'{ROW_ITEM,  3'd0,       64'd0, -16'sd32768, 16'sd32767, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd32767, -16'sd32768, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, -16'sd1, 16'sd1, 1'b0, NONE},
		'{ROW_WRITE, REG_A_ROW0, 64'hFFFF_0000_0000_0000, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_A_ROW1, 64'h8000_0000_0000_0000, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_A_ROW2, 64'h0001_0000_0000_0000, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_C_ROW,  64'h0000_0000_0000_0000, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd1234, 16'sd0, 1'b1,
			'{24'sd0, 24'sd1234, 24'sd0, 24'sd0}},
		'{ROW_WRITE, REG_B_COL,  64'h5A5A_0000_0000_0000, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_L_COL,  64'hABCD_7FFF_7FFF_7FFF, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd5, 16'sd32767, 1'b1,
			'{24'sd0, 24'sd524256, 24'sd524256, 24'sd524256}},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd5, -16'sd32768, 1'b1,
			'{24'sd0, -24'sd524272, -24'sd524272, -24'sd524272}},
		'{ROW_WRITE, REG_L_COL,  64'h0123_8000_8000_8000, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd0, -16'sd32768, 1'b1,
			'{24'sd0, 24'sd524288, 24'sd524288, 24'sd524288}},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd0, 16'sd32767, 1'b1,
			'{24'sd0, -24'sd524272, -24'sd524272, -24'sd524272}},
		'{ROW_WRITE, REG_A_ROW0, 64'h0000_7FFF_7FFF_7FFF, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_A_ROW1, 64'hFFFF_7FFF_7FFF_7FFF, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_A_ROW2, 64'h1234_7FFF_7FFF_7FFF, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_B_COL,  64'h0000_7FFF_7FFF_7FFF, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_C_ROW,  64'h0000_7FFF_7FFF_7FFF, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd32767, 16'sd32767, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd32767, 16'sd32767, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd32767, 16'sd32767, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, -16'sd32768, -16'sd32768, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_A_ROW0, 64'h0000_8000_8000_8000, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_A_ROW1, 64'h0000_8000_8000_8000, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_A_ROW2, 64'h0000_8000_8000_8000, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_B_COL,  64'h0000_8000_8000_8000, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, -16'sd32768, 16'sd32767, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd32767, -16'sd32768, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_SPARE7, 64'h0000_1234_5678_9ABC, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd100, -16'sd100, 1'b0, NONE},
		'{ROW_WRITE, REG_A_ROW0, {16'hFFFF, RST_A_ROW0}, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_A_ROW1, {16'h0000, RST_A_ROW1}, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_A_ROW2, {16'h0000, RST_A_ROW2}, 16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_B_COL,  {16'h0000, RST_B_COL},  16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_C_ROW,  {16'h0000, RST_C_ROW},  16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_WRITE, REG_L_COL,  {16'h0000, RST_L_COL},  16'sd0, 16'sd0, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, 16'sd1000, 16'sd200, 1'b0, NONE},
		'{ROW_ITEM,  3'd0,       64'd0, -16'sd1000, -16'sd200, 1'b0, NONE}
	};

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic signed [SW-1:0]       u_sample  = '0;
	logic signed [SW-1:0]       y_sample  = '0;
	logic                       out_stall = 1'b0;
	logic                       psel      = 1'b0;
	logic                       penable   = 1'b0;
	logic                       pwrite    = 1'b0;
	logic [ADDR_W-1:0]          paddr     = '0;
	logic [DATA_W-1:0]          pwdata    = '0;
	wire                        in_stall;
	wire                        out_valid;
	wire signed [XW-1:0]        y_predicted;
	wire signed [XW-1:0]        x0_estimate;
	wire signed [XW-1:0]        x1_estimate;
	wire signed [XW-1:0]        x2_estimate;
	wire [DATA_W-1:0]           prdata;
	wire                        pready;

	estimate_t            pending_estimates [$];
	logic [REG_W-1:0]     coef_shadow [REG_COUNT];
	logic signed [XW-1:0] state_shadow [3];
	int                   fail_count   = 0;
	int                   report_count = 0;
	int                   samples_sent = 0;
	int                   results_seen = 0;
	int                   stall_left   = 0;
	bit                   tx_calm      = 1'b0;
	bit                   rx_calm      = 1'b0;

	luenberger_state_observer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.u_sample   (u_sample),
		.y_sample   (y_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.y_predicted(y_predicted),
		.x0_estimate(x0_estimate),
		.x1_estimate(x1_estimate),
		.x2_estimate(x2_estimate),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #CLK_HALF clk = ~clk;

	function automatic longint coef_at(int r, int k);
		logic signed [COEF_W-1:0] c;
		c = coef_shadow[r][COEF_W*k +: COEF_W];
		return longint'(c);
	endfunction

	// floor division by 2^FRAC
	function automatic longint scaled(longint c, longint v);
		return (c * v) >>> FRAC;
	endfunction

	function automatic longint clamp(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (XW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic estimate_t observer_step(logic signed [SW-1:0] u, logic signed [SW-1:0] y);
		longint               yhat;
		longint               innov;
		longint               acc;
		logic signed [XW-1:0] next [3];
		estimate_t            r;
		yhat = 0;
		for (int j = 0; j < 3; j++)
			yhat += scaled(coef_at(REG_C_ROW, j), longint'(state_shadow[j]));
		yhat = clamp(yhat);
		innov = longint'(y) - yhat;
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += scaled(coef_at(i, j), longint'(state_shadow[j]));
			acc += scaled(coef_at(REG_B_COL, i), longint'(u));
			acc += scaled(coef_at(REG_L_COL, i), innov);
			next[i] = XW'(clamp(acc));
		end
		for (int i = 0; i < 3; i++)
			state_shadow[i] = next[i];
		r.y_predicted = XW'(yhat);
		r.x0 = next[0];
		r.x1 = next[1];
		r.x2 = next[2];
		return r;
	endfunction

	function automatic logic [63:0] random_reg(coef_mode_t mode, int idx);
		logic [63:0] v;
		logic [15:0] c;
		v = {$urandom, $urandom};
		if (mode == COEF_RESET) begin
			v[REG_W-1:0] = RESET_VALUES[idx];
		end else if (mode != COEF_FULL) begin
			for (int k = 0; k < 3; k++) begin
				case (mode)
					COEF_GENTLE: c = 16'($urandom_range(0, 1023)) - 16'd512;
					COEF_SMALL:  c = 16'($urandom_range(0, 8191)) - 16'd4096;
					default: begin
						case ($urandom_range(0, 3))
							0:       c = 16'h7FFF;
							1:       c = 16'h8000;
							2:       c = 16'h0000;
							default: c = 16'($urandom);
						endcase
					end
				endcase
				v[COEF_W*k +: COEF_W] = c;
			end
		end
		return v;
	endfunction

	function automatic logic signed [SW-1:0] random_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return SW'($urandom);
			6, 7:             return SW'($urandom_range(0, 255)) - 16'sd128;
			8:                return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default:          return SW'($urandom_range(0, 2)) - 16'sd1;
		endcase
	endfunction

	task automatic send_sample(input logic signed [SW-1:0] u, input logic signed [SW-1:0] y,
			output estimate_t predicted);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		u_sample <= u;
		y_sample <= y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = observer_step(u, y);
		samples_sent++;
		if (samples_sent % 40 == 0)
			tx_calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 3'b000});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx < REG_COUNT)
			coef_shadow[idx] = val[REG_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_estimates.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic check_result();
		estimate_t got;
		estimate_t want;
		got = '{y_predicted, x0_estimate, x1_estimate, x2_estimate};
		if (pending_estimates.size() == 0) begin
			fail_count++;
			if (report_count < MAX_REPORTS)
				$display("unexpected transfer: yhat=%0d x=%0d %0d %0d",
					got.y_predicted, got.x0, got.x1, got.x2);
			report_count++;
		end else begin
			want = pending_estimates.pop_front();
			if (got !== want) begin
				fail_count++;
				if (report_count < MAX_REPORTS)
					$display("mismatch: exp yhat=%0d x=%0d %0d %0d, got yhat=%0d x=%0d %0d %0d",
						want.y_predicted, want.x0, want.x1, want.x2,
						got.y_predicted, got.x0, got.x1, got.x2);
				report_count++;
			end
		end
	endtask

	// stall countdown runs only while a result is offered
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
				stall_left = rx_calm ? 0 : $urandom_range(0, 15);
				results_seen++;
				if (results_seen % 40 == 0)
					rx_calm = ($urandom_range(0, 3) == 0);
			end else if (out_valid && stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left > 0);
		end
	end

	initial begin
		estimate_t  predicted;
		coef_mode_t mode;
		for (int r = 0; r < REG_COUNT; r++)
			coef_shadow[r] = RESET_VALUES[r];
		for (int i = 0; i < 3; i++)
			state_shadow[i] = '0;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < DIRECTED_ROWS; n++) begin
			if (DIRECTED[n].kind == ROW_WRITE) begin
				settle();
				write_reg(DIRECTED[n].reg_idx, DIRECTED[n].value);
			end else begin
				send_sample(DIRECTED[n].u, DIRECTED[n].y, predicted);
				pending_estimates.push_back(DIRECTED[n].typed ? DIRECTED[n].result : predicted);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			mode = coef_mode_t'(p % 5);
			settle();
			for (int r = 0; r < REG_COUNT; r++)
				write_reg(r[2:0], random_reg(mode, r));
			if ($urandom_range(0, 1))
				write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, {$urandom, $urandom});
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_sample(random_sample(), random_sample(), predicted);
				pending_estimates.push_back(predicted);
			end
		end

		settle();
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
